### design/isa_pkg.sv
// shared types and constants for the interval slot allocator
`default_nettype none

package isa_pkg;

    // fixed field widths of the request and result words
    localparam int TIME_W    = 20;
    localparam int TAG_W     = 16;
    localparam int SLOT_ID_W = 6;
    localparam int PEAK_W    = 7;

    // default sizing of the slot bank
    localparam int SLOTS_DEFAULT     = 64;
    localparam int TIME_BITS_DEFAULT = 20;

    // request word
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
        logic [TAG_W-1:0]  tag;
    } req_t;

    // result word
    typedef struct packed {
        logic [SLOT_ID_W-1:0] slot_id;
        logic                 granted;
        logic [TAG_W-1:0]     tag_out;
        logic [PEAK_W-1:0]    peak_in_use;
    } rsp_t;

endpackage

`default_nettype wire

### design/isa_slot_bank.sv
// slot bank: per-slot end times, expiry comparators and lowest-free-slot pick
`default_nettype none

module isa_slot_bank
    import isa_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    localparam int PICK_W   = $clog2(SLOTS)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    input  wire logic [TIME_BITS-1:0] start_time,
    input  wire logic [TIME_BITS-1:0] end_time,
    output logic                      found,
    output logic [PICK_W-1:0]         pick
);

    logic [SLOTS-1:0]     busy_reg;
    logic [SLOTS-1:0]     busy_next;
    logic [TIME_BITS-1:0] end_reg [SLOTS];
    logic [SLOTS-1:0]     expire;
    logic [SLOTS-1:0]     busy_left;
    logic [SLOTS-1:0]     grant_vec;

    // free every busy slot whose end lies strictly before the new start
    always_comb
    begin
        for (int s = 0; s < SLOTS; s++)
        begin
            expire[s] = busy_reg[s] && (end_reg[s] < start_time);
        end
        busy_left = busy_reg & ~expire;
    end

    // priority encoder: lowest numbered free slot wins
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!busy_left[s])
            begin
                found = 1'b1;
                pick  = PICK_W'(s);
            end
        end
    end

    // next busy vector: expired slots cleared, granted slot set
    always_comb
    begin
        grant_vec = '0;
        if (found)
        begin
            grant_vec[pick] = 1'b1;
        end
        busy_next = busy_reg;
        if (req_valid)
        begin
            busy_next = busy_left | grant_vec;
        end
    end

    // busy flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    // stored end times, only read while the slot is busy
    always_ff @(posedge clk)
    begin
        if (req_valid && found)
        begin
            end_reg[pick] <= end_time;
        end
    end

endmodule

`default_nettype wire

### design/interval_slot_allocator.sv
// top level of the greedy interval slot allocator
`default_nettype none

// Greedy interval partitioning over SLOTS slots. Raise start with a request
// word (requests in non-decreasing start order); busy is always low, so a
// word is taken on every cycle that start is high. Each request gives one
// result word on result, marked by done for a single cycle: the word lands
// in the input register when it is taken and passes through the expiry
// comparators and priority encoder into the result register. The receiver
// cannot stall, so done and result must be captured when they appear.
// Slots whose end time is below the new start are freed, then the lowest
// free slot is granted; granted is low when every slot is busy. peak_in_use
// is the largest number of slots busy at once, kept as one past the highest
// slot ever granted, which lowest-first allocation makes the same figure.

module interval_slot_allocator
    import isa_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire req_t req,
    output logic      done,
    output rsp_t      result
);

    localparam int PICK_W    = $clog2(SLOTS);
    localparam int PEAK_BITS = $clog2(SLOTS + 1);

    req_t                 item_reg;
    logic                 item_valid_reg;
    logic [TIME_BITS-1:0] item_start;
    logic [TIME_BITS-1:0] item_end;
    logic                 found;
    logic [PICK_W-1:0]    pick;
    logic [PEAK_BITS-1:0] peak_reg;
    logic [PEAK_BITS-1:0] peak_next;
    logic [PEAK_BITS-1:0] peak_cand;
    rsp_t                 result_reg;
    rsp_t                 result_next;
    logic                 done_reg;

    // a word is taken on every cycle
    assign busy = 1'b0;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= req;
        end
    end

    // times brought to the internal width
    assign item_start = TIME_BITS'(item_reg.start_time);
    assign item_end   = TIME_BITS'(item_reg.end_time);

    isa_slot_bank #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_slot_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (item_valid_reg),
        .start_time (item_start),
        .end_time   (item_end),
        .found      (found),
        .pick       (pick)
    );

    // running peak and result word
    always_comb
    begin
        peak_cand = PEAK_BITS'(pick) + PEAK_BITS'(1);
        peak_next = peak_reg;
        if (item_valid_reg && found && (peak_cand > peak_reg))
        begin
            peak_next = peak_cand;
        end
        result_next.slot_id     = found ? SLOT_ID_W'(pick) : '0;
        result_next.granted     = found;
        result_next.tag_out     = item_reg.tag;
        result_next.peak_in_use = PEAK_W'(peak_next);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            peak_reg <= peak_next;
            done_reg <= item_valid_reg;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (item_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench for the interval slot allocator
`default_nettype none

module tb;
    import isa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SLOT_COUNT = SLOTS_DEFAULT;
    localparam int unsigned TIME_TOP   = (1 << TIME_W) - 1;
    localparam int          PRINT_CAP  = 40;

    // greedy slot model plus the queue of result words still to arrive
    class slot_scoreboard;
        rsp_t        awaited[$];
        int unsigned mismatches;
        bit                slot_taken [SLOT_COUNT];
        logic [TIME_W-1:0] slot_free_at [SLOT_COUNT];
        int unsigned       in_use;
        int unsigned       peak;

        function new();
            foreach (slot_taken[s])
            begin
                slot_taken[s]   = 1'b0;
                slot_free_at[s] = '0;
            end
            in_use     = 0;
            peak       = 0;
            mismatches = 0;
        endfunction

        // free expired slots, then grant the lowest free one
        function rsp_t grant_slot(req_t w);
            rsp_t r;
            int   pick;
            bit   found;
            r     = '0;
            pick  = 0;
            found = 1'b0;
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                if (slot_taken[s] && slot_free_at[s] < w.start_time)
                begin
                    slot_taken[s] = 1'b0;
                    if (in_use > 0)
                        in_use--;
                end
            end
            for (int s = 0; s < SLOT_COUNT; s++)
            begin
                if (!found && !slot_taken[s])
                begin
                    pick  = s;
                    found = 1'b1;
                end
            end
            if (found)
            begin
                slot_taken[pick]   = 1'b1;
                slot_free_at[pick] = w.end_time;
                in_use++;
                if (in_use > peak)
                    peak = in_use;
            end
            r.slot_id     = found ? SLOT_ID_W'(pick) : '0;
            r.granted     = found;
            r.tag_out     = w.tag;
            r.peak_in_use = PEAK_W'(peak);
            return r;
        endfunction

        function void note_request(req_t w);
            awaited.push_back(grant_slot(w));
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_CAP)
                $display("%0t ns mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        // compare one result word with the oldest expected word
        task check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result word %h", got));
                return;
            end
            want = awaited.pop_front();
            if (got.slot_id !== want.slot_id)
                report_mismatch($sformatf("tag %h slot_id %0d, expected %0d",
                                          want.tag_out, got.slot_id, want.slot_id));
            if (got.granted !== want.granted)
                report_mismatch($sformatf("tag %h granted %b, expected %b",
                                          want.tag_out, got.granted, want.granted));
            if (got.tag_out !== want.tag_out)
                report_mismatch($sformatf("tag_out %h, expected %h",
                                          got.tag_out, want.tag_out));
            if (got.peak_in_use !== want.peak_in_use)
                report_mismatch($sformatf("tag %h peak_in_use %0d, expected %0d",
                                          want.tag_out, got.peak_in_use, want.peak_in_use));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t result;

    slot_scoreboard board = new();

    int unsigned next_start;
    int          burst_left;

    interval_slot_allocator dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // watch accepted request words and delivered result words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(result);
            if (start && !busy)
                board.note_request(req);
        end
    end

    // hold a request word until it is taken
    task automatic send_word(input logic [TIME_W-1:0] s, input logic [TIME_W-1:0] e,
                             input logic [TAG_W-1:0] t);
        req_t w;
        w.start_time = s;
        w.end_time   = e;
        w.tag        = t;
        start <= 1'b1;
        req   <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // bursts of back-to-back words separated by random gaps
    task automatic pace();
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
    endtask

    // stop sending until every expected word is back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (board.awaited.size() != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned clamp_time(int unsigned v);
        return (v > TIME_TOP - 1) ? TIME_TOP - 1 : v;
    endfunction

    // one stretch of random requests; crowded stretches overfill the bank
    task automatic run_segment(input int k, input int style, input int count);
        int unsigned s;
        int unsigned e;
        bit          crowd;
        if (next_start < k * 32'h1F000)
            next_start = k * 32'h1F000 + $urandom_range(0, 255);
        for (int i = 0; i < count; i++)
        begin
            pace();
            crowd = (style == 1) || (style == 2 && $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
            begin
                // out of order start, end possibly below start
                s = $urandom_range(0, TIME_TOP);
                e = $urandom_range(0, 1) ? $urandom_range(0, s) : $urandom_range(0, TIME_TOP);
            end
            else
            begin
                if (crowd)
                    next_start = clamp_time(next_start + $urandom_range(0, 2));
                else if ($urandom_range(0, 3) != 0)
                    next_start = clamp_time(next_start + $urandom_range(0, 4000));
                s = next_start;
                e = clamp_time(s + (crowd ? $urandom_range(40000, 70000)
                                          : $urandom_range(0, 6000)));
            end
            send_word(s[TIME_W-1:0], e[TIME_W-1:0], TAG_W'($urandom_range(0, 16'hFFFF)));
        end
    endtask

    // run limit
    initial
    begin
        #2_000_000;
        $display("interval_slot_allocator verification failed");
        $finish;
    end

    // stimulus and verdict
    initial
    begin
        int styles [8];
        styles     = '{2, 0, 1, 2, 0, 2, 1, 2};
        next_start = 0;
        burst_left = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        req   <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero times, equal ends not freed, end below start,
        // start below the previous one, the top of the time range
        send_word(20'h00000, 20'h00000, 16'h0000);
        send_word(20'h00000, 20'h00000, 16'hFFFF);
        send_word(20'h00001, 20'h00005, 16'hA5A5);
        send_word(20'h0000A, 20'h00003, 16'h5A5A);
        send_word(20'h00004, 20'h00004, 16'h0001);
        send_word(20'h00002, 20'h00002, 16'h0002);
        start <= 1'b0;
        @(posedge clk);
        send_word(20'h00002, 20'hFFFFE, 16'h0003);
        send_word(20'h7FFFF, 20'h80000, 16'h8000);
        send_word(20'h80000, 20'h80000, 16'h7FFF);
        send_word(20'h80001, 20'h80001, 16'h1234);
        send_word(20'h00005, 20'hFFFFE, 16'hFEDC);
        send_word(20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        send_word(20'h00000, 20'h00000, 16'h0004);
        wait_drained();

        // random stretches, sometimes fully drained in between
        for (int k = 0; k < 8; k++)
        begin
            run_segment(k, styles[k], (styles[k] == 1) ? 80 : 45);
            if ($urandom_range(0, 1) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (8)
            @(posedge clk);
        if (board.awaited.size() != 0)
            board.report_mismatch($sformatf("%0d result words never arrived",
                                            board.awaited.size()));
        if (board.mismatches == 0)
            $display("interval_slot_allocator verification clean");
        else
            $display("interval_slot_allocator verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### interval_slot_allocator.f
design/isa_pkg.sv
design/isa_slot_bank.sv
design/interval_slot_allocator.sv
tb/tb.sv
